// File: rtl/n_extrema_with_suppression_unit_assert.svh
// Assertion macros used by the checker file of the extrema unit.
`ifndef N_EXTREMA_WITH_SUPPRESSION_UNIT_ASSERT_SVH
`define N_EXTREMA_WITH_SUPPRESSION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NEXS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NEXS_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/nexs_pkg.sv
`timescale 1ns / 1ps

package nexs_pkg;

    // Capacity and sizes
    localparam int MAX_FRAMES   = 1024;
    localparam int MAX_RESULTS  = 16;
    localparam int SAMPLE_WIDTH = 32;

    localparam int FRAME_AW  = $clog2(MAX_FRAMES);       // store address
    localparam int CNT_W     = $clog2(MAX_FRAMES + 1);   // frame count
    localparam int SPAN_W    = CNT_W + 1;                // pick + radius + 1
    localparam int SLOT_W    = $clog2(MAX_RESULTS + 1);  // slot count
    localparam int RCOUNT_W  = 5;
    localparam int RADIUS_W  = 10;
    localparam int INDEX_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_MINIMUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_RADIUS  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic                           sample_valid;
        logic                           last_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] result_value;
        logic [INDEX_W-1:0]             frame_index;
        logic                           found;
        logic                           last_result;
    } t_out_item;

endpackage

// File: rtl/nexs_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data
module nexs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/n_extrema_with_suppression_unit.sv
`timescale 1ns / 1ps
// Load: one frame per cycle; the input stalls from the last frame to the final result.
// Search: each slot up to the first empty one is found by a scan of the loaded frames (one
// store read per cycle) and then waits in the output register until its transfer; a found
// slot that is not the last then marks up to 2 * mask_radius + 1 exclusion entries, one per
// cycle. Empty slots after the first empty one follow one per cycle while the output does not stall.
// Reset (synchronous, active low) initialises control state, the load and slot counters and configuration.
module n_extrema_with_suppression_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // frame input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  nexs_pkg::t_in_item                  i_in_data,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output nexs_pkg::t_out_item                 o_out_data,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nexs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nexs_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int SW = nexs_pkg::SAMPLE_WIDTH;
    localparam int AW = nexs_pkg::FRAME_AW;
    localparam int CW = nexs_pkg::CNT_W;
    localparam int PW = nexs_pkg::SPAN_W;
    localparam int LW = nexs_pkg::SLOT_W;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_MARK = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                          r_find_min;
    logic [nexs_pkg::RCOUNT_W-1:0] r_result_count;
    logic [nexs_pkg::RADIUS_W-1:0] r_radius;

    // sequence and slot control
    logic [CW-1:0] r_loaded, n_loaded;
    logic [CW-1:0] r_n, n_n;
    logic [LW-1:0] r_slots, n_slots;
    logic [LW-1:0] r_slot, n_slot;

    // scan pipeline
    logic [CW-1:0] r_addr, n_addr;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_pos, n_pend_pos;

    // best candidate of the current pass
    logic                 r_have, n_have;
    logic signed [SW-1:0] r_best, n_best;
    logic [AW-1:0]        r_best_pos, n_best_pos;

    // exclusion window
    logic [AW-1:0] r_mk, n_mk;
    logic [CW-1:0] r_to, n_to;

    // memory ports
    logic          frm_wr_en;
    logic [AW-1:0] frm_wr_addr;
    logic [SW:0]   frm_wr_data;
    logic [SW:0]   frm_rd_data;
    logic          msk_wr_en;
    logic [AW-1:0] msk_wr_addr;
    logic          msk_wr_data;
    logic          msk_rd_data;

    logic in_xfer, out_xfer, slot_last;
    logic rd_valid, cand, better;
    logic signed [SW-1:0] rd_value;
    logic [PW-1:0] win_lo, win_hi;
    logic [LW-1:0] slots_clamped;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_xfer  = o_out_valid && !i_out_stall;
    assign slot_last = (r_slot + LW'(1)) == r_slots;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_cfg_ready = 1'b1;

    // Result payload, held in registers until the transfer
    assign o_out_data.result_value = r_have ? r_best : '0;
    assign o_out_data.frame_index  = r_have ? nexs_pkg::INDEX_W'(r_best_pos) : '0;
    assign o_out_data.found        = r_have;
    assign o_out_data.last_result  = slot_last;

    // Frame store: {valid, value}
    nexs_ram #(
        .WIDTH (SW + 1),
        .DEPTH (nexs_pkg::MAX_FRAMES)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (frm_wr_en),
        .i_wr_addr (frm_wr_addr),
        .i_wr_data (frm_wr_data),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (frm_rd_data)
    );

    // Exclusion mask: cleared per entry on load, set by the marking pass
    nexs_ram #(
        .WIDTH (1),
        .DEPTH (nexs_pkg::MAX_FRAMES)
    ) u_mask_ram (
        .i_clk     (i_clk),
        .i_wr_en   (msk_wr_en),
        .i_wr_addr (msk_wr_addr),
        .i_wr_data (msk_wr_data),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (msk_rd_data)
    );

    // Store writes during load
    assign frm_wr_en   = in_xfer && (r_loaded < CW'(nexs_pkg::MAX_FRAMES));
    assign frm_wr_addr = r_loaded[AW-1:0];
    assign frm_wr_data = {i_in_data.sample_valid, i_in_data.sample_value};

    assign msk_wr_en   = frm_wr_en || (r_state == ST_MARK);
    assign msk_wr_addr = (r_state == ST_MARK) ? r_mk : r_loaded[AW-1:0];
    assign msk_wr_data = (r_state == ST_MARK);

    // Shared compare unit
    assign rd_valid = frm_rd_data[SW];
    assign rd_value = $signed(frm_rd_data[SW-1:0]);
    assign cand     = r_pend && rd_valid && !msk_rd_data;
    assign better   = !r_have || (r_find_min ? (rd_value < r_best) : (rd_value > r_best));

    // Exclusion window around the pick, clamped to the sequence
    always_comb begin
        win_lo = (r_best_pos > AW'(r_radius)) ? PW'(r_best_pos) - PW'(r_radius) : '0;
        win_hi = PW'(r_best_pos) + PW'(r_radius) + PW'(1);
        if (win_hi > PW'(r_n)) begin
            win_hi = PW'(r_n);
        end
    end

    // Slot count clamp
    always_comb begin
        slots_clamped = LW'(r_result_count);
        if (r_result_count == '0) begin
            slots_clamped = LW'(1);
        end else if (LW'(r_result_count) > LW'(nexs_pkg::MAX_RESULTS)) begin
            slots_clamped = LW'(nexs_pkg::MAX_RESULTS);
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_n        = r_n;
        n_slots    = r_slots;
        n_slot     = r_slot;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_pend_pos = r_pend_pos;
        n_have     = r_have;
        n_best     = r_best;
        n_best_pos = r_best_pos;
        n_mk       = r_mk;
        n_to       = r_to;
        unique case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (frm_wr_en) begin
                        n_loaded = r_loaded + CW'(1);
                    end
                    if (i_in_data.last_frame) begin
                        n_state = ST_SCAN;
                        n_n     = frm_wr_en ? r_loaded + CW'(1) : r_loaded;
                        n_slots = slots_clamped;
                        n_slot  = '0;
                        n_addr  = '0;
                        n_have  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, compare the data of the previous one
                if (r_addr < r_n) begin
                    n_addr     = r_addr + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_pos = r_addr[AW-1:0];
                end
                if (cand && better) begin
                    n_have     = 1'b1;
                    n_best     = rd_value;
                    n_best_pos = r_pend_pos;
                end
                if ((r_addr == r_n) && !r_pend) begin
                    n_state = ST_EMIT;
                    n_mk    = win_lo[AW-1:0];
                    n_to    = win_hi[CW-1:0];
                end
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    n_slot = r_slot + LW'(1);
                    if (slot_last) begin
                        n_state  = ST_LOAD;
                        n_loaded = '0;
                    end else if (r_have) begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if ((CW'(r_mk) + CW'(1)) == r_to) begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                    n_have  = 1'b0;
                end else begin
                    n_mk = r_mk + AW'(1);
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_loaded <= '0;
            r_slot   <= '0;
            r_slots  <= LW'(1);
            r_pend   <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_slot   <= n_slot;
            r_slots  <= n_slots;
            r_pend   <= n_pend;
            r_have   <= n_have;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_addr     <= n_addr;
        r_pend_pos <= n_pend_pos;
        r_best     <= n_best;
        r_best_pos <= n_best_pos;
        r_mk       <= n_mk;
        r_to       <= n_to;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_min     <= 1'b0;
            r_result_count <= nexs_pkg::RCOUNT_W'(1);
            r_radius       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                nexs_pkg::CFG_FIND_MINIMUM: r_find_min     <= i_cfg_data[0];
                nexs_pkg::CFG_RESULT_COUNT: r_result_count <= i_cfg_data[nexs_pkg::RCOUNT_W-1:0];
                nexs_pkg::CFG_MASK_RADIUS:  r_radius       <= i_cfg_data[nexs_pkg::RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/nexs_checker.sv
`timescale 1ns / 1ps
`include "n_extrema_with_suppression_unit_assert.svh"

// Port-level checks of the extrema unit
module nexs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input nexs_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input nexs_pkg::t_out_item o_out_data
);

    logic in_xfer, out_xfer;
    logic out_empty, empty_zero, empty_more, last_out, load_more;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    assign out_empty  = o_out_valid && !o_out_data.found;
    assign empty_zero = (o_out_data.result_value == '0) && (o_out_data.frame_index == '0);
    assign empty_more = out_xfer && !o_out_data.found && !o_out_data.last_result;
    assign last_out   = out_xfer && o_out_data.last_result;
    assign load_more  = in_xfer && !i_in_data.last_frame;

    // no frame taken while a result is pending
    `NEXS_ASSERT_IMP(a_no_load_during_emit, o_out_valid, o_in_stall, "frame taken during results")

    // an empty slot carries zeros
    `NEXS_ASSERT_IMP(a_empty_slot_zero, out_empty, empty_zero, "empty slot not zero")

    // once exhausted, the following slot comes at once and is empty too
    `NEXS_ASSERT_NXT(a_exhausted_stays, empty_more, out_empty, "pick after exhaustion")

    // after the final slot the unit takes frames again
    `NEXS_ASSERT_NXT(a_reopen_after_last, last_out, !o_in_stall, "input closed after last result")

    // loading continues until the last frame
    `NEXS_ASSERT_NXT(a_load_continues, load_more, !o_in_stall, "input closed before last frame")

endmodule

bind n_extrema_with_suppression_unit nexs_checker u_nexs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
